// ===== hdl/ktt_pkg.sv =====
// ----------------------------------------------------------------------------
// ktt_pkg
// types and constants shared by the keyed tag table and its cells
// ----------------------------------------------------------------------------
package ktt_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned TAG_W = 4;
  localparam int unsigned ST_W  = 3;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_SET    = 1'b1
  } act_e;

  typedef enum logic [ST_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_APPENDED = 3'd3,
    ST_DROPPED  = 3'd4
  } status_e;

  // item walking down the row of cells
  typedef struct packed {
    logic             vld;
    act_e             act;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] res_tag;
    status_e          st;
    logic             done;
  } tok_t;

endpackage

// ===== hdl/ktt_cell.sv =====
// ----------------------------------------------------------------------------
// ktt_cell
// one table entry: compares, updates or appends as the item passes by
// ----------------------------------------------------------------------------
module ktt_cell #(
  parameter int unsigned CNT_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CNT_W-1:0]   fill_i,
  input  ktt_pkg::tok_t      tok_i,
  output ktt_pkg::tok_t      tok_o
);
  import ktt_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [KEY_W-1:0] key_q;
  logic [TAG_W-1:0] tag_q;
  tok_t             tok_d;
  tok_t             tok_q;
  logic             vld_q;
  logic             active;
  logic             hit;
  logic             app;

  assign active = tok_i.vld && !tok_i.done;
  // only filled entries take part in the compare
  assign hit    = active && (MyIdx < fill_i) && (key_q == tok_i.key);
  // first empty entry takes the key of an unmatched set
  assign app    = active && !hit && (MyIdx == fill_i) && (tok_i.act == ACT_SET);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.done = 1'b1;
      if (tok_i.act == ACT_SET) begin
        tok_d.res_tag = tok_i.tag;
        tok_d.st      = ST_UPDATED;
      end else begin
        tok_d.res_tag = tag_q;
        tok_d.st      = ST_HIT;
      end
    end else if (app) begin
      tok_d.done    = 1'b1;
      tok_d.res_tag = tok_i.tag;
      tok_d.st      = ST_APPENDED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (app) begin
      key_q <= tok_i.key;
    end
    if (app || (hit && (tok_i.act == ACT_SET))) begin
      tag_q <= tok_i.tag;
    end
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end

endmodule

// ===== hdl/keyed_tag_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_tag_table_top
// append-only keyed table mapping a 64-bit key to a 4-bit tag
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   tvalid / tready         tuser: action; tdata: page_key, tag_in
//  m_axis    out  tvalid / tready         tuser: status; tdata: tag_out
//  cfg       in   cfg_we_i                cfg_wdata_i: unset_tag
//
//  an item walks the row of TABLE_DEPTH cells, one cell a cycle, then a
//  result stage; one item in flight.
//  the result waits in an output register while the next item walks.
//  reset clears the fill count and the unset tag; entries are not cleared.
//  a stalled output holds the next result in the result stage.
module keyed_tag_table_top #(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [63:0] page_key, [67:64] tag_in, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] tag_out, rest zero
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);
  import ktt_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(TABLE_DEPTH);

  tok_t             chain [TABLE_DEPTH+1];
  tok_t             exit_tok;
  logic             accept;
  logic             busy_q;
  logic [CNT_W-1:0] fill_q;
  logic [TAG_W-1:0] unset_q;
  logic             exit_app;
  logic [TAG_W-1:0] res_tag;
  status_e          res_st;
  logic             pend_vld_q;
  logic [TAG_W-1:0] pend_tag_q;
  status_e          pend_st_q;
  logic             out_vld_q;
  logic [TAG_W-1:0] out_tag_q;
  status_e          out_st_q;
  logic             out_free;
  logic             move;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    chain[0].vld     = accept;
    chain[0].act     = act_e'(s_axis_tuser[0]);
    chain[0].key     = s_axis_tdata[KEY_W-1:0];
    chain[0].tag     = s_axis_tdata[KEY_W+TAG_W-1:KEY_W];
    chain[0].res_tag = '0;
    chain[0].st      = ST_HIT;
    chain[0].done    = 1'b0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ktt_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .fill_i (fill_q),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  assign exit_tok = chain[TABLE_DEPTH];
  assign exit_app = exit_tok.vld && exit_tok.done && (exit_tok.st == ST_APPENDED);

  // an unresolved set only gets here when the table is full
  always_comb begin
    if (exit_tok.done) begin
      res_tag = exit_tok.res_tag;
      res_st  = exit_tok.st;
    end else if (exit_tok.act == ACT_SET) begin
      res_tag = '0;
      res_st  = ST_DROPPED;
    end else begin
      res_tag = unset_q;
      res_st  = ST_MISS;
    end
  end

  assign out_free = !out_vld_q || m_axis_tready;
  assign move     = pend_vld_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      fill_q     <= '0;
      unset_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (exit_app) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (cfg_we_i) begin
        unset_q <= cfg_wdata_i;
      end
      if (exit_tok.vld) begin
        pend_vld_q <= 1'b1;
      end else if (move) begin
        pend_vld_q <= 1'b0;
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_tok.vld) begin
      pend_tag_q <= res_tag;
      pend_st_q  <= res_st;
    end
    if (move) begin
      out_tag_q <= pend_tag_q;
      out_st_q  <= pend_st_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_tag_q};
  assign m_axis_tuser  = out_st_q;

`ifndef SYNTH
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullCnt)
    else $error("fill count beyond table depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("item accepted but block not busy");

  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_tok.vld |-> (busy_q && !pend_vld_q))
    else $error("item left the cells with no item in flight");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> $past(exit_app))
    else $error("fill count moved without an append");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exit_tok.vld && !exit_tok.done && (exit_tok.act == ACT_SET)) |-> (fill_q == FullCnt))
    else $error("set dropped while table has room");
`endif

endmodule
